// ===== rtl/cnv3_pkg.sv =====
// Types, widths and register codes shared by the 3x3 window convolution block.
`default_nettype none

package cnv3_pkg;

	// Sample and result widths
	localparam int SAMPLE_BITS = 16;
	localparam int PROD_BITS   = 2 * SAMPLE_BITS;
	localparam int SUM_BITS    = 35;
	localparam int TAPS        = 9;

	// Position and size widths
	localparam int DIM_BITS    = 13;
	localparam int ROW_BITS    = 12;
	localparam int OCOL_BITS   = 10;
	localparam int WIDTH_BITS  = 11;
	localparam int HEIGHT_BITS = 13;
	localparam int WIDX_BITS   = 4;

	localparam logic [DIM_BITS-1:0] MIN_DIM    = 13'd3;
	localparam logic [DIM_BITS-1:0] MAX_HEIGHT = 13'd4096;

	// Configuration port
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;
	localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd1024;

	// Request opcodes
	typedef enum logic {
		OP_WEIGHT = 1'b0,
		OP_PIXEL  = 1'b1
	} opcode_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef sample_t [TAPS-1:0] taps_t;
	typedef logic signed [SUM_BITS-1:0] sum_t;

endpackage

`default_nettype wire

// ===== rtl/cnv3_if.sv =====
// Valid/ready channel interfaces for requests and results of the convolution block.
`default_nettype none

interface cnv3_in_if;
	logic                               valid;
	logic                               ready;
	logic                               opcode;
	logic [cnv3_pkg::WIDX_BITS-1:0]     weight_index;
	logic signed [cnv3_pkg::SAMPLE_BITS-1:0] weight_value;
	logic signed [cnv3_pkg::SAMPLE_BITS-1:0] pixel_value;
	logic                               frame_start;

	modport source (output valid, opcode, weight_index, weight_value, pixel_value,
		frame_start, input ready);
	modport sink (input valid, opcode, weight_index, weight_value, pixel_value,
		frame_start, output ready);
endinterface

interface cnv3_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [cnv3_pkg::SUM_BITS-1:0] window_sum;
	logic [cnv3_pkg::ROW_BITS-1:0]      out_row;
	logic [cnv3_pkg::OCOL_BITS-1:0]     out_column;
	logic                               frame_last;

	modport source (output valid, window_sum, out_row, out_column, frame_last,
		input ready);
	modport sink (input valid, window_sum, out_row, out_column, frame_last,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/cnv3_dot.sv =====
// Nine-tap dot product: registered products, then an adder tree into 35 bits.
`default_nettype none

module cnv3_dot (
	input  wire logic           clk,
	input  wire logic           load,
	input  wire cnv3_pkg::taps_t pix,
	input  wire cnv3_pkg::taps_t wgt,
	output cnv3_pkg::sum_t      sum
);

	logic signed [cnv3_pkg::PROD_BITS-1:0] prod_s2 [cnv3_pkg::TAPS];
	cnv3_pkg::sum_t a0, a1, a2, a3, b0, b1;

	// Product register, one multiplier per tap
	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < cnv3_pkg::TAPS; k++) begin
				prod_s2[k] <= cnv3_pkg::PROD_BITS'(signed'(pix[k]) * signed'(wgt[k]));
			end
		end
	end

	// Balanced adder tree; the sum is exact, no overflow possible
	always_comb begin
		a0  = cnv3_pkg::SUM_BITS'(prod_s2[0]) + cnv3_pkg::SUM_BITS'(prod_s2[1]);
		a1  = cnv3_pkg::SUM_BITS'(prod_s2[2]) + cnv3_pkg::SUM_BITS'(prod_s2[3]);
		a2  = cnv3_pkg::SUM_BITS'(prod_s2[4]) + cnv3_pkg::SUM_BITS'(prod_s2[5]);
		a3  = cnv3_pkg::SUM_BITS'(prod_s2[6]) + cnv3_pkg::SUM_BITS'(prod_s2[7]);
		b0  = a0 + a1;
		b1  = a2 + a3;
		sum = b0 + b1 + cnv3_pkg::SUM_BITS'(prod_s2[8]);
	end

endmodule

`default_nettype wire

// ===== rtl/conv3x3_stride1_window_top.sv =====
// Streaming 3x3 stride-1 convolution with a two-row line store and a 3x3 window.
// A pixel that completes a window passes stage 1, the product register and the result register to res.
// Throughput: one request per cycle while res does not stall; the line store is a single dual-address
// memory read at accept time and written when the pixel leaves stage 1.
// Reset (arst_n low, asynchronous): counters, window and weights clear to zero,
// width and height return to 1024; line store contents stay undefined.
`default_nettype none

module conv3x3_stride1_window_top #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	cnv3_in_if.sink                              inp,
	cnv3_out_if.source                           res,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [cnv3_pkg::ADDR_BITS-1:0]  paddr,
	input  wire logic [cnv3_pkg::DATA_BITS-1:0]  pwdata,
	output logic      [cnv3_pkg::DATA_BITS-1:0]  prdata,
	output logic                                 pready
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int DB = cnv3_pkg::DIM_BITS;
	localparam int SB = cnv3_pkg::SAMPLE_BITS;
	localparam logic [DB-1:0] MAX_W = DB'(MAX_WIDTH);

	// Configuration registers
	logic [cnv3_pkg::WIDTH_BITS-1:0]  width_q;
	logic [cnv3_pkg::HEIGHT_BITS-1:0] height_q;
	logic                             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= cnv3_pkg::WIDTH_RESET;
			height_q <= cnv3_pkg::HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				cnv3_pkg::REG_WIDTH:  width_q  <= pwdata[cnv3_pkg::WIDTH_BITS-1:0];
				cnv3_pkg::REG_HEIGHT: height_q <= pwdata[cnv3_pkg::HEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			cnv3_pkg::REG_WIDTH:  prdata = cnv3_pkg::DATA_BITS'(width_q);
			cnv3_pkg::REG_HEIGHT: prdata = cnv3_pkg::DATA_BITS'(height_q);
			default:              prdata = '0;
		endcase
	end

	// Saturated frame size
	logic [DB-1:0] w_sat, h_sat, w_ext, h_ext;

	always_comb begin
		w_ext = DB'(width_q);
		h_ext = DB'(height_q);
		if (w_ext < cnv3_pkg::MIN_DIM)
			w_sat = cnv3_pkg::MIN_DIM;
		else if (w_ext > MAX_W)
			w_sat = MAX_W;
		else
			w_sat = w_ext;
		if (h_ext < cnv3_pkg::MIN_DIM)
			h_sat = cnv3_pkg::MIN_DIM;
		else if (h_ext > cnv3_pkg::MAX_HEIGHT)
			h_sat = cnv3_pkg::MAX_HEIGHT;
		else
			h_sat = h_ext;
	end

	// Pipeline handshake: each stage moves when the one after it has room
	logic v_s1, v_s2, out_v_q;
	logic en_s1, en_s2, en_out;
	logic accept, is_pix, s1_leave, s1_pix, s2_load;

	assign en_out   = !out_v_q | res.ready;
	assign en_s2    = !v_s2 | en_out;
	assign en_s1    = !v_s1 | en_s2;
	assign inp.ready = en_s1;
	assign accept   = inp.valid & en_s1;
	assign is_pix   = (inp.opcode == cnv3_pkg::OP_PIXEL);

	// Position counters, advanced when a pixel is accepted
	logic [AW-1:0]                 col_q;
	logic [cnv3_pkg::ROW_BITS-1:0] row_q;
	logic [DB-1:0] c0, r0, c1, r1, r2, cn, rn, col_d, row_d;
	logic          emit_d, last_d;

	always_comb begin
		c0 = inp.frame_start ? '0 : DB'(col_q);
		r0 = inp.frame_start ? '0 : DB'(row_q);
		if (c0 >= w_sat) begin
			c1 = '0;
			r1 = r0 + 1'b1;
		end else begin
			c1 = c0;
			r1 = r0;
		end
		r2 = (r1 >= h_sat) ? '0 : r1;
		cn = c1 + 1'b1;
		rn = r2 + 1'b1;
		if (cn >= w_sat) begin
			col_d = '0;
			row_d = (rn >= h_sat) ? '0 : rn;
		end else begin
			col_d = cn;
			row_d = r2;
		end
		emit_d = (r2 >= DB'(2)) && (c1 >= DB'(2));
		last_d = (r2 == h_sat - 1'b1) && (c1 == w_sat - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept && is_pix) begin
			col_q <= col_d[AW-1:0];
			row_q <= row_d[cnv3_pkg::ROW_BITS-1:0];
		end
	end

	// Stage 1 registers
	logic                             op_s1;
	logic [cnv3_pkg::WIDX_BITS-1:0]   widx_s1;
	cnv3_pkg::sample_t                wval_s1, pix_s1;
	logic [AW-1:0]                    c_s1;
	logic                             emit_s1, last_s1;
	logic [cnv3_pkg::ROW_BITS-1:0]    orow_s1;
	logic [cnv3_pkg::OCOL_BITS-1:0]   ocol_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en_s1)
			v_s1 <= inp.valid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= inp.opcode;
			widx_s1 <= inp.weight_index;
			wval_s1 <= inp.weight_value;
			pix_s1  <= inp.pixel_value;
			c_s1    <= c1[AW-1:0];
			emit_s1 <= emit_d;
			last_s1 <= last_d;
			orow_s1 <= cnv3_pkg::ROW_BITS'(r2 - DB'(2));
			ocol_s1 <= cnv3_pkg::OCOL_BITS'(c1 - DB'(2));
		end
	end

	assign s1_leave = v_s1 & en_s2;
	assign s1_pix   = (op_s1 == cnv3_pkg::OP_PIXEL);
	assign s2_load  = s1_leave & s1_pix & emit_s1;

	// Line store: entry holds {row two above, row one above} for a column
	logic [2*SB-1:0] line_mem [MAX_WIDTH];
	logic [2*SB-1:0] rd_s1, byp_data_s1, line_s1, wdata;
	logic            byp_s1, line_wr;

	assign line_s1 = byp_s1 ? byp_data_s1 : rd_s1;
	assign wdata   = {line_s1[SB-1:0], pix_s1};
	assign line_wr = s1_leave & s1_pix;

	always_ff @(posedge clk) begin
		if (en_s1)
			rd_s1 <= line_mem[c1[AW-1:0]];
		if (line_wr)
			line_mem[c_s1] <= wdata;
	end

	// Forward the entry being written when the next pixel reads the same column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			byp_s1 <= 1'b0;
		else if (en_s1)
			byp_s1 <= line_wr && (c_s1 == c1[AW-1:0]);
	end

	always_ff @(posedge clk) begin
		if (en_s1)
			byp_data_s1 <= wdata;
	end

	// Window columns and kernel weights, updated in request order
	cnv3_pkg::sample_t win_q  [6];
	cnv3_pkg::sample_t kern_q [cnv3_pkg::TAPS];
	cnv3_pkg::sample_t col3   [3];

	assign col3[0] = line_s1[2*SB-1:SB];
	assign col3[1] = line_s1[SB-1:0];
	assign col3[2] = pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 6; j++)
				win_q[j] <= '0;
			for (int k = 0; k < cnv3_pkg::TAPS; k++)
				kern_q[k] <= '0;
		end else if (s1_leave) begin
			if (s1_pix) begin
				for (int j = 0; j < 3; j++) begin
					win_q[j]     <= win_q[3 + j];
					win_q[3 + j] <= col3[j];
				end
			end else if (widx_s1 < cnv3_pkg::WIDX_BITS'(cnv3_pkg::TAPS)) begin
				kern_q[widx_s1] <= wval_s1;
			end
		end
	end

	// Taps in kernel order: row i, columns c-2, c-1, c
	cnv3_pkg::taps_t pix_taps, wgt_taps;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pix_taps[3*i]     = win_q[i];
			pix_taps[3*i + 1] = win_q[3 + i];
			pix_taps[3*i + 2] = col3[i];
			wgt_taps[3*i]     = kern_q[3*i];
			wgt_taps[3*i + 1] = kern_q[3*i + 1];
			wgt_taps[3*i + 2] = kern_q[3*i + 2];
		end
	end

	cnv3_pkg::sum_t dot_sum;

	cnv3_dot u_dot (
		.clk  (clk),
		.load (s2_load),
		.pix  (pix_taps),
		.wgt  (wgt_taps),
		.sum  (dot_sum)
	);

	// Stage 2 position fields
	logic [cnv3_pkg::ROW_BITS-1:0]  orow_s2;
	logic [cnv3_pkg::OCOL_BITS-1:0] ocol_s2;
	logic                           last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en_s2)
			v_s2 <= s2_load;
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			orow_s2 <= orow_s1;
			ocol_s2 <= ocol_s1;
			last_s2 <= last_s1;
		end
	end

	// Result register
	cnv3_pkg::sum_t                 sum_q;
	logic [cnv3_pkg::ROW_BITS-1:0]  orow_q;
	logic [cnv3_pkg::OCOL_BITS-1:0] ocol_q;
	logic                           last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (en_out)
			out_v_q <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (v_s2 && en_out) begin
			sum_q  <= dot_sum;
			orow_q <= orow_s2;
			ocol_q <= ocol_s2;
			last_q <= last_s2;
		end
	end

	assign res.valid      = out_v_q;
	assign res.window_sum = sum_q;
	assign res.out_row    = orow_q;
	assign res.out_column = ocol_q;
	assign res.frame_last = last_q;

	// Checks
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		DB'(col_q) < MAX_W)
		else $error("column counter beyond line store depth");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!inp.ready |-> (v_s1 && v_s2 && out_v_q))
		else $error("request side stalled with a free pipeline stage");

	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && en_out) |=> out_v_q)
		else $error("stage 2 result lost on its way to the result register");

	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.frame_last) |->
		(res.out_column == cnv3_pkg::OCOL_BITS'(w_sat - DB'(3))))
		else $error("frame end flagged away from the last output column");

endmodule

`default_nettype wire

// ===== tb/sv/conv3x3_stride1_window_top_tb.sv =====
// Self-checking testbench for the streaming 3x3 stride-1 window convolution block.
module conv3x3_stride1_window_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cnv3_pkg::*;

	localparam int MAX_WIDTH     = 1024;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 500000;

	typedef struct {
		opcode_t                op;
		logic [WIDX_BITS-1:0]   widx;
		sample_t                wval;
		sample_t                pval;
		logic                   fs;
	} conv_request_t;

	typedef struct {
		sum_t                   sum;
		logic [ROW_BITS-1:0]    row;
		logic [OCOL_BITS-1:0]   col;
		logic                   last;
	} conv_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [ADDR_BITS-1:0]   paddr;
	logic [DATA_BITS-1:0]   pwdata;
	logic [DATA_BITS-1:0]   prdata;
	logic                   pready;

	cnv3_in_if  inp_ch ();
	cnv3_out_if res_ch ();

	conv3x3_stride1_window_top #(
		.MAX_WIDTH(MAX_WIDTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.inp(inp_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Shadow of the block: kernel, line rows, window, position and size registers
	sample_t                kernel [TAPS];
	sample_t                row_above2 [MAX_WIDTH];
	sample_t                row_above1 [MAX_WIDTH];
	sample_t                window [6];
	int unsigned            col_pos;
	int unsigned            row_pos;
	logic [WIDTH_BITS-1:0]  width_reg;
	logic [HEIGHT_BITS-1:0] height_reg;

	conv_request_t          request_queue [$];
	conv_result_t           pending_sums [$];
	bit                     failed = 1'b0;
	int                     sender_idle_pct;
	int                     receiver_idle_pct;

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int unsigned effective_width(input logic [WIDTH_BITS-1:0] raw);
		if (raw < MIN_DIM)
			return MIN_DIM;
		if (raw > MAX_WIDTH)
			return MAX_WIDTH;
		return raw;
	endfunction

	// Advance the shadow by one accepted request; a full window queues its sum
	task automatic convolve_request(input conv_request_t rq);
		int unsigned w;
		int unsigned h;
		sample_t column [3];
		longint acc;
		conv_result_t rs;
		if (rq.op == OP_WEIGHT) begin
			if (rq.widx < TAPS)
				kernel[rq.widx] = rq.wval;
			return;
		end
		w = effective_width(width_reg);
		h = (height_reg < MIN_DIM) ? MIN_DIM :
			(height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
		if (rq.fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		// column past a shrunken width starts the next row
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		column[0] = row_above2[col_pos];
		column[1] = row_above1[col_pos];
		column[2] = rq.pval;
		row_above2[col_pos] = column[1];
		row_above1[col_pos] = column[2];
		if (row_pos >= 2 && col_pos >= 2) begin
			acc = 0;
			for (int i = 0; i < 3; i++) begin
				acc += longint'(window[i]) * longint'(kernel[3*i])
					+ longint'(window[3+i]) * longint'(kernel[3*i+1])
					+ longint'(column[i]) * longint'(kernel[3*i+2]);
			end
			rs.sum = acc[SUM_BITS-1:0];
			rs.row = ROW_BITS'(row_pos - 2);
			rs.col = OCOL_BITS'(col_pos - 2);
			rs.last = (row_pos == h - 1) && (col_pos == w - 1);
			pending_sums.push_back(rs);
		end
		for (int j = 0; j < 3; j++) begin
			window[j] = window[3+j];
			window[3+j] = column[j];
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
	endtask

	function automatic sample_t random_sample();
		case ($urandom_range(7, 0))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic void push_request(input opcode_t op, input logic [WIDX_BITS-1:0] widx,
		input sample_t wval, input sample_t pval, input logic fs);
		conv_request_t rq;
		rq.op = op;
		rq.widx = widx;
		rq.wval = wval;
		rq.pval = pval;
		rq.fs = fs;
		request_queue.push_back(rq);
	endfunction

	// Wait for every queued request and expected sum, then let the pipeline settle
	task automatic drain();
		while (request_queue.size() != 0 || pending_sums.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready
	task automatic reg_write(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// One configuration phase of requests; clean phases hold pixels only and open a fresh frame
	task automatic run_phase(input logic [WIDTH_BITS-1:0] w_set,
		input logic [HEIGHT_BITS-1:0] h_set, input int count, input bit clean);
		bit restart;
		// a wider row needs a fresh frame so no unwritten line entry is read
		restart = clean || (effective_width(w_set) > effective_width(width_reg))
			|| ($urandom_range(1, 0) == 1);
		reg_write({REG_WIDTH, 2'b00}, DATA_BITS'(w_set));
		width_reg = w_set;
		reg_write({REG_HEIGHT, 2'b00}, DATA_BITS'(h_set));
		height_reg = h_set;
		for (int n = 0; n < count; n++) begin
			// hold off midway until the block has delivered everything
			if (n == count / 2)
				drain();
			if (!clean && $urandom_range(99, 0) < 12)
				push_request(OP_WEIGHT, WIDX_BITS'($urandom), sample_t'($urandom),
					sample_t'($urandom), 1'($urandom));
			else begin
				// the first pixel of the phase opens the fresh frame
				push_request(OP_PIXEL, WIDX_BITS'($urandom), sample_t'($urandom),
					random_sample(),
					restart || (!clean && $urandom_range(99, 0) == 0));
				restart = 1'b0;
			end
		end
		drain();
	endtask

	// Request driver: retire at the rising edge, present the next at the falling edge
	always @(posedge clk) begin : request_driver
		bit taken;
		taken = inp_ch.valid && inp_ch.ready;
		if (taken)
			convolve_request(request_queue.pop_front());
		@(negedge clk);
		if (!inp_ch.valid || taken) begin
			if (request_queue.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
				inp_ch.valid <= 1'b1;
				inp_ch.opcode <= request_queue[0].op;
				inp_ch.weight_index <= request_queue[0].widx;
				inp_ch.weight_value <= request_queue[0].wval;
				inp_ch.pixel_value <= request_queue[0].pval;
				inp_ch.frame_start <= request_queue[0].fs;
			end else begin
				inp_ch.valid <= 1'b0;
			end
		end
	end

	// Result monitor: compare each accepted result with the oldest expected sum
	always @(posedge clk) begin : result_monitor
		conv_result_t want;
		if (res_ch.valid && res_ch.ready) begin
			if (pending_sums.size() == 0) begin
				$error("unexpected result: window_sum %0d out_row %0d out_column %0d",
					res_ch.window_sum, res_ch.out_row, res_ch.out_column);
				failed = 1'b1;
			end else begin
				want = pending_sums.pop_front();
				if (res_ch.window_sum !== want.sum) begin
					$error("window_sum: expected %0d, got %0d", want.sum, res_ch.window_sum);
					failed = 1'b1;
				end
				if (res_ch.out_row !== want.row) begin
					$error("out_row: expected %0d, got %0d", want.row, res_ch.out_row);
					failed = 1'b1;
				end
				if (res_ch.out_column !== want.col) begin
					$error("out_column: expected %0d, got %0d", want.col, res_ch.out_column);
					failed = 1'b1;
				end
				if (res_ch.frame_last !== want.last) begin
					$error("frame_last: expected %0d, got %0d", want.last, res_ch.frame_last);
					failed = 1'b1;
				end
			end
		end
		@(negedge clk);
		res_ch.ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
	end

	// Run limit
	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Reset, directed requests, random phases, tall frame
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		inp_ch.valid = 1'b0;
		inp_ch.opcode = OP_WEIGHT;
		inp_ch.weight_index = '0;
		inp_ch.weight_value = '0;
		inp_ch.pixel_value = '0;
		inp_ch.frame_start = 1'b0;
		res_ch.ready = 1'b0;
		sender_idle_pct = 8;
		receiver_idle_pct = 88;
		for (int i = 0; i < TAPS; i++)
			kernel[i] = '0;
		for (int i = 0; i < 6; i++)
			window[i] = '0;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			row_above2[i] = '0;
			row_above1[i] = '0;
		end
		col_pos = 0;
		row_pos = 0;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every tap at the most negative weight; loads ignore frame_start and pixel
		for (int i = 0; i < TAPS; i++)
			push_request(OP_WEIGHT, WIDX_BITS'(i), 16'sh8000, 16'sh1234, 1'b0);
		// out-of-range tap indexes are dropped
		push_request(OP_WEIGHT, 4'd9, 16'sh7fff, '0, 1'b1);
		push_request(OP_WEIGHT, 4'd15, 16'sh0001, 16'sh7fff, 1'b1);
		// two pixels at the reset frame size, no window yet
		push_request(OP_PIXEL, 4'd15, 16'sh7fff, 16'sh7fff, 1'b1);
		push_request(OP_PIXEL, 4'd0, '0, 16'sh8000, 1'b0);
		drain();

		// smallest frame: largest positive sum, then most negative sum
		reg_write({REG_WIDTH, 2'b00}, 32'd3);
		width_reg = 11'd3;
		reg_write({REG_HEIGHT, 2'b00}, 32'd3);
		height_reg = 13'd3;
		for (int i = 0; i < 9; i++)
			push_request(OP_PIXEL, '0, '0, 16'sh8000, i == 0);
		for (int i = 0; i < 9; i++)
			push_request(OP_PIXEL, '0, '0, 16'sh7fff, i == 0);
		drain();

		// random phases under three idle patterns
		for (int p = 0; p < 12; p++) begin
			sender_idle_pct = (p < 4) ? 8 : (p < 8) ? 88 : 0;
			receiver_idle_pct = (p < 4) ? 88 : (p < 8) ? 8 : 0;
			run_phase(WIDTH_BITS'($urandom_range(12, 0)), HEIGHT_BITS'($urandom_range(8, 0)),
				110, 1'b0);
		end

		// saturating register values: narrowest rows in a frame of the largest height
		run_phase(11'd0, 13'd8191, 600, 1'b1);

		if (!failed)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
